// ===== design/cwrp_pkg.sv =====
// Package for the write-multiple-coils request parser.
// Holds the shared constants, codes and the header check result type.
// No dependencies.
package cwrp_pkg;

    localparam int MAX_QUANTITY_DEF = 1968;
    localparam int COILS_W          = 11;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;
    localparam int OUT_DATA_W       = 32;
    localparam int OUT_USER_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COIL_LOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COIL_HIGH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_CAPACITY = 2'd3;

    localparam logic [1:0] KIND_COIL   = 2'd0;
    localparam logic [1:0] KIND_RESP   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_REQ_TRUNC  = 2'd1;
    localparam logic [1:0] STATUS_RESP_TRUNC = 2'd2;

    localparam logic [1:0] EXC_NONE  = 2'd0;
    localparam logic [1:0] EXC_ADDR  = 2'd2;
    localparam logic [1:0] EXC_VALUE = 2'd3;

    localparam logic [7:0] MIN_NORMAL_CAP = 8'd4;

    typedef struct packed {
        logic       done;
        logic [1:0] exc;
    } chk_result_t;

endpackage

// ===== design/coil_write_request_parser.sv =====
// Write-multiple-coils request parser, top level. Depends on cwrp_pkg, cwrp_hdr_check.
// The fifth header byte starts the header check: one to nine steps of the shared add/subtract
// unit. A data byte gives up to 8 coil writes, then on the last one 5 response bytes and a
// status follow; each result passes through the output register.
// Synchronous active-low reset restores the register defaults and the start of a request.
module coil_write_request_parser #(
    parameter int MAX_QUANTITY = cwrp_pkg::MAX_QUANTITY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // req_byte[7:0]
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_coil_addr[15:0], out_coil_value[16], out_resp_byte[24:17], out_status[26:25]
    output logic [cwrp_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [cwrp_pkg::OUT_USER_W-1:0]   m_tuser,   // out_kind[1:0]
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [cwrp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cwrp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {ST_IN, ST_CHECK, ST_COIL, ST_RESP, ST_EXC, ST_FIN} st_t;
    typedef enum logic [1:0] {PH_HEADER, PH_DATA, PH_SKIP} phase_t;

    st_t                          state_reg;
    phase_t                       phase_reg;
    logic [2:0]                   hidx_reg;
    logic [6:0]                   fc_reg;
    logic [15:0]                  low_reg;
    logic [15:0]                  high_reg;
    logic [7:0]                   cap_reg;
    logic [15:0]                  sa_reg;
    logic [15:0]                  qty_reg;
    logic [7:0]                   bc_reg;
    logic [cwrp_pkg::COILS_W-1:0] left_reg;
    logic [15:0]                  addr_reg;
    logic [7:0]                   byte_reg;
    logic                         last_reg;
    logic [2:0]                   k_reg;
    logic [2:0]                   idx_reg;
    logic [1:0]                   fin_status_reg;
    logic [1:0]                   exc_reg;
    logic                         m_tvalid_reg;
    logic [cwrp_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [cwrp_pkg::OUT_USER_W-1:0] m_tuser_reg;
    logic                         m_tlast_reg;

    logic                  s_accept;
    logic                  slot_free;
    logic                  chk_start;
    logic                  coil_done;
    logic [7:0]            resp_byte;
    cwrp_pkg::chk_result_t chk;

    function automatic logic [cwrp_pkg::OUT_DATA_W-1:0] pack_out(
        input logic [15:0] addr,
        input logic        value,
        input logic [7:0]  resp,
        input logic [1:0]  status
    );
        pack_out = {5'd0, status, resp, value, addr};
    endfunction

    assign s_tready  = (state_reg == ST_IN);
    assign s_accept  = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign chk_start = s_accept && (phase_reg == PH_HEADER) && (hidx_reg == 3'd4);
    assign coil_done = (k_reg == 3'd7) || (left_reg == 11'd1);

    always_comb begin
        case (idx_reg)
            3'd0:    resp_byte = {1'b0, fc_reg};
            3'd1:    resp_byte = sa_reg[15:8];
            3'd2:    resp_byte = sa_reg[7:0];
            3'd3:    resp_byte = qty_reg[15:8];
            default: resp_byte = qty_reg[7:0];
        endcase
    end

    cwrp_hdr_check #(
        .MAX_QUANTITY (MAX_QUANTITY)
    ) u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (chk_start),
        .start_address (sa_reg),
        .coil_quantity (qty_reg),
        .byte_count    (bc_reg),
        .coil_low      (low_reg),
        .coil_high     (high_reg),
        .result        (chk)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg   <= 7'd15;
            low_reg  <= 16'h0000;
            high_reg <= 16'hFFFF;
            cap_reg  <= 8'd253;
        end else if (cfg_we) begin
            case (cfg_index)
                cwrp_pkg::CFG_FUNCTION_CODE: fc_reg   <= cfg_data[6:0];
                cwrp_pkg::CFG_COIL_LOW:      low_reg  <= cfg_data;
                cwrp_pkg::CFG_COIL_HIGH:     high_reg <= cfg_data;
                cwrp_pkg::CFG_RESP_CAPACITY: cap_reg  <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IN;
            phase_reg    <= PH_HEADER;
            hidx_reg     <= 3'd0;
            sa_reg       <= 16'd0;
            qty_reg      <= 16'd0;
            bc_reg       <= 8'd0;
            left_reg     <= '0;
            addr_reg     <= 16'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IN: begin
                    if (s_accept) begin
                        last_reg <= s_tlast;
                        case (phase_reg)
                            PH_SKIP: begin
                                if (s_tlast) begin
                                    phase_reg <= PH_HEADER;
                                end
                            end
                            PH_HEADER: begin
                                case (hidx_reg)
                                    3'd0:    sa_reg[15:8]  <= s_tdata;
                                    3'd1:    sa_reg[7:0]   <= s_tdata;
                                    3'd2:    qty_reg[15:8] <= s_tdata;
                                    3'd3:    qty_reg[7:0]  <= s_tdata;
                                    default: bc_reg        <= s_tdata;
                                endcase
                                hidx_reg <= hidx_reg + 3'd1;
                                if (hidx_reg == 3'd4) begin
                                    state_reg <= ST_CHECK;
                                end else if (s_tlast) begin
                                    fin_status_reg <= cwrp_pkg::STATUS_REQ_TRUNC;
                                    state_reg      <= ST_FIN;
                                end
                            end
                            default: begin
                                byte_reg  <= s_tdata;
                                k_reg     <= 3'd0;
                                state_reg <= ST_COIL;
                            end
                        endcase
                    end
                end
                ST_CHECK: begin
                    if (chk.done) begin
                        exc_reg <= chk.exc;
                        idx_reg <= 3'd0;
                        if (chk.exc != cwrp_pkg::EXC_NONE) begin
                            if (cap_reg == 8'd0) begin
                                fin_status_reg <= cwrp_pkg::STATUS_RESP_TRUNC;
                                state_reg      <= ST_FIN;
                            end else begin
                                state_reg <= ST_EXC;
                            end
                        end else if (cap_reg < cwrp_pkg::MIN_NORMAL_CAP) begin
                            fin_status_reg <= cwrp_pkg::STATUS_RESP_TRUNC;
                            state_reg      <= ST_FIN;
                        end else begin
                            left_reg  <= qty_reg[cwrp_pkg::COILS_W-1:0];
                            addr_reg  <= sa_reg;
                            phase_reg <= PH_DATA;
                            hidx_reg  <= 3'd0;
                            if (last_reg) begin
                                fin_status_reg <= cwrp_pkg::STATUS_REQ_TRUNC;
                                state_reg      <= ST_FIN;
                            end else begin
                                state_reg <= ST_IN;
                            end
                        end
                    end
                end
                ST_COIL: begin
                    if (slot_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= pack_out(addr_reg, byte_reg[k_reg], 8'd0,
                                                 cwrp_pkg::STATUS_OK);
                        m_tuser_reg  <= cwrp_pkg::KIND_COIL;
                        m_tlast_reg  <= coil_done && (left_reg != 11'd1) && !last_reg;
                        left_reg     <= left_reg - 11'd1;
                        addr_reg     <= addr_reg + 16'd1;
                        k_reg        <= k_reg + 3'd1;
                        if (coil_done) begin
                            if (left_reg == 11'd1) begin
                                idx_reg   <= 3'd0;
                                state_reg <= ST_RESP;
                            end else if (last_reg) begin
                                fin_status_reg <= cwrp_pkg::STATUS_REQ_TRUNC;
                                state_reg      <= ST_FIN;
                            end else begin
                                state_reg <= ST_IN;
                            end
                        end
                    end
                end
                ST_RESP: begin
                    if (slot_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= pack_out(16'd0, 1'b0, resp_byte, cwrp_pkg::STATUS_OK);
                        m_tuser_reg  <= cwrp_pkg::KIND_RESP;
                        m_tlast_reg  <= 1'b0;
                        idx_reg      <= idx_reg + 3'd1;
                        if (idx_reg == 3'd4) begin
                            fin_status_reg <= cwrp_pkg::STATUS_OK;
                            state_reg      <= ST_FIN;
                        end
                    end
                end
                ST_EXC: begin
                    if (slot_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= pack_out(16'd0, 1'b0,
                                                 (idx_reg == 3'd0) ? {1'b1, fc_reg}
                                                                   : {6'd0, exc_reg},
                                                 cwrp_pkg::STATUS_OK);
                        m_tuser_reg  <= cwrp_pkg::KIND_RESP;
                        m_tlast_reg  <= 1'b0;
                        idx_reg      <= idx_reg + 3'd1;
                        if (idx_reg != 3'd0) begin
                            fin_status_reg <= cwrp_pkg::STATUS_OK;
                            state_reg      <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    if (slot_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= pack_out(16'd0, 1'b0, 8'd0, fin_status_reg);
                        m_tuser_reg  <= cwrp_pkg::KIND_STATUS;
                        m_tlast_reg  <= 1'b1;
                        phase_reg    <= last_reg ? PH_HEADER : PH_SKIP;
                        hidx_reg     <= 3'd0;
                        state_reg    <= ST_IN;
                    end
                end
                default: begin
                    state_reg <= ST_IN;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_check_only_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        chk.done |-> (state_reg == ST_CHECK))
        else $error("header check finished outside the check state");

    a_data_has_coils: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_IN) && (phase_reg == PH_DATA)) |-> (left_reg != 11'd0))
        else $error("data phase entered with no coils left");

    a_header_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IN) |-> (hidx_reg <= 3'd4))
        else $error("header index beyond the header");

    a_finish_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FIN) && slot_free) |=>
            (m_tvalid && m_tlast && (m_tuser == cwrp_pkg::KIND_STATUS)))
        else $error("finishing status not presented as the last result");

endmodule

// ===== design/cwrp_hdr_check.sv =====
// Header checker: runs the quantity, address range and byte count checks
// one at a time through a single shared 17-bit add/subtract unit.
// Depends on cwrp_pkg.
module cwrp_hdr_check #(
    parameter int MAX_QUANTITY = cwrp_pkg::MAX_QUANTITY_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [15:0]           start_address,
    input  logic [15:0]           coil_quantity,
    input  logic [7:0]            byte_count,
    input  logic [15:0]           coil_low,
    input  logic [15:0]           coil_high,
    output cwrp_pkg::chk_result_t result
);

    typedef enum logic [3:0] {
        CK_IDLE, CK_QLO, CK_QHI, CK_SLO, CK_SHI, CK_QM1, CK_END, CK_ELO, CK_EHI, CK_BC
    } ck_state_t;

    ck_state_t   state_reg;
    logic [15:0] qm1_reg;
    logic [15:0] end_reg;
    logic        done_reg;
    logic [1:0]  exc_reg;

    logic [15:0] op_a;
    logic [15:0] op_b;
    logic        op_sub;
    logic [16:0] sum;

    always_comb begin
        op_a   = coil_quantity;
        op_b   = 16'd1;
        op_sub = 1'b1;
        case (state_reg)
            CK_QHI: begin
                op_a = 16'(MAX_QUANTITY);
                op_b = coil_quantity;
            end
            CK_SLO: begin
                op_a = start_address;
                op_b = coil_low;
            end
            CK_SHI: begin
                op_a = coil_high;
                op_b = start_address;
            end
            CK_END: begin
                op_a   = start_address;
                op_b   = qm1_reg;
                op_sub = 1'b0;
            end
            CK_ELO: begin
                op_a = end_reg;
                op_b = coil_low;
            end
            CK_EHI: begin
                op_a = coil_high;
                op_b = end_reg;
            end
            CK_BC: begin
                op_a = {8'd0, byte_count};
                op_b = {3'd0, qm1_reg[15:3]};
            end
            default: begin
                op_a = coil_quantity;
            end
        endcase
        sum = {1'b0, op_a} + (op_sub ? ~{1'b0, op_b} : {1'b0, op_b}) + {16'd0, op_sub};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CK_IDLE;
            done_reg  <= 1'b0;
            exc_reg   <= cwrp_pkg::EXC_NONE;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                CK_IDLE: begin
                    if (start) begin
                        state_reg <= CK_QLO;
                    end
                end
                CK_QLO, CK_QHI: begin
                    if (sum[16]) begin
                        done_reg  <= 1'b1;
                        exc_reg   <= cwrp_pkg::EXC_VALUE;
                        state_reg <= CK_IDLE;
                    end else begin
                        state_reg <= (state_reg == CK_QLO) ? CK_QHI : CK_SLO;
                    end
                end
                CK_SLO, CK_SHI, CK_ELO: begin
                    if (sum[16]) begin
                        done_reg  <= 1'b1;
                        exc_reg   <= cwrp_pkg::EXC_ADDR;
                        state_reg <= CK_IDLE;
                    end else if (state_reg == CK_SLO) begin
                        state_reg <= CK_SHI;
                    end else if (state_reg == CK_SHI) begin
                        state_reg <= CK_QM1;
                    end else begin
                        state_reg <= CK_EHI;
                    end
                end
                CK_QM1: begin
                    qm1_reg   <= sum[15:0];
                    state_reg <= CK_END;
                end
                CK_END: begin
                    end_reg <= sum[15:0];
                    if (sum[16]) begin
                        done_reg  <= 1'b1;
                        exc_reg   <= cwrp_pkg::EXC_ADDR;
                        state_reg <= CK_IDLE;
                    end else begin
                        state_reg <= CK_ELO;
                    end
                end
                CK_EHI: begin
                    if (sum[16]) begin
                        done_reg  <= 1'b1;
                        exc_reg   <= cwrp_pkg::EXC_ADDR;
                        state_reg <= CK_IDLE;
                    end else begin
                        state_reg <= CK_BC;
                    end
                end
                CK_BC: begin
                    done_reg  <= 1'b1;
                    exc_reg   <= (sum == 17'd1) ? cwrp_pkg::EXC_NONE : cwrp_pkg::EXC_VALUE;
                    state_reg <= CK_IDLE;
                end
                default: begin
                    state_reg <= CK_IDLE;
                end
            endcase
        end
    end

    assign result.done = done_reg;
    assign result.exc  = exc_reg;

endmodule
